// ===== design/button_tap_hold_gesture_counter_macros.svh =====
// assertion helpers for the gesture counter
// each one samples on clk and is off while rst_n is low
`ifndef BUTTON_TAP_HOLD_GESTURE_COUNTER_MACROS_SVH
`define BUTTON_TAP_HOLD_GESTURE_COUNTER_MACROS_SVH

// same-cycle implication
`define BTG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define BTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/btg_pkg.sv =====
package btg_pkg;

  // field widths
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // press kinds
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_TAP  = 2'd1;
  localparam kind_t KIND_HOLD = 2'd2;

  // register indexes
  localparam cfg_idx_t REG_TAP_THRESHOLD  = 1'd0;
  localparam cfg_idx_t REG_HOLD_THRESHOLD = 1'd1;

  // register reset values
  localparam tick_t TAP_THRESHOLD_RST  = 16'd80;
  localparam tick_t HOLD_THRESHOLD_RST = 16'd1500;

endpackage

// ===== design/btg_if.sv =====
// input channel: one button level per beat
interface btg_in_if;
  import btg_pkg::*;
  logic valid;
  logic ready;
  logic pressed;
  modport source (output valid, output pressed, input ready);
  modport sink (input valid, input pressed, output ready);
endinterface

// result channel: one finished gesture per beat
interface btg_out_if;
  import btg_pkg::*;
  logic   valid;
  logic   ready;
  count_t press_count;
  kind_t  press_kind;
  modport source (output valid, output press_count, output press_kind, input ready);
  modport sink (input valid, input press_count, input press_kind, output ready);
endinterface

// configuration write channel
interface btg_cfg_if;
  import btg_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  tick_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/button_tap_hold_gesture_counter.sv =====
// channel   dir  payload                          handshake
// in_ch     in   pressed (1)                      valid / ready
// out_ch    out  press_count (8), press_kind (2)  valid / ready
// cfg_ch    in   index (1), data (16)             valid / ready, always ready
//
// one tick per cycle unless out_ch stalls; a finishing tick passes both registers to out_ch
// the path is input register, gesture update logic, result register
// rst_n is synchronous: thresholds go to 80 and 1500, gesture state clears
// a full result register that is not taken stalls the input register and in_ch
// in_ch ready depends on out_ch ready through that stall path
module button_tap_hold_gesture_counter
  import btg_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  btg_in_if.sink    in_ch,
  btg_out_if.source out_ch,
  btg_cfg_if.sink   cfg_ch
);

  // threshold registers
  tick_t tap_thr_r;
  tick_t hold_thr_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_thr_r  <= TAP_THRESHOLD_RST;
      hold_thr_r <= HOLD_THRESHOLD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TAP_THRESHOLD:  tap_thr_r  <= cfg_ch.data;
        REG_HOLD_THRESHOLD: hold_thr_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic stg_valid_r;
  logic stg_level_r;
  logic out_valid_r;
  count_t out_count_r;
  kind_t  out_kind_r;
  logic advance;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !stg_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_level_r <= in_ch.pressed;
    end
  end

  // gesture state
  logic   prev_level_r, prev_level_nxt;
  logic   in_gesture_r, in_gesture_nxt;
  tick_t  down_r, down_nxt;
  tick_t  up_r, up_nxt;
  kind_t  kind_r, kind_nxt;
  count_t count_r, count_nxt;
  logic   finish;
  count_t count_inc;

  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  // per-tick update
  always_comb begin
    prev_level_nxt = stg_level_r;
    in_gesture_nxt = in_gesture_r;
    down_nxt       = down_r;
    up_nxt         = up_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    finish         = 1'b0;
    if (!in_gesture_r) begin
      if (stg_level_r && !prev_level_r) begin
        in_gesture_nxt = 1'b1;
        down_nxt       = tick_t'(1);
        up_nxt         = '0;
        kind_nxt       = KIND_NONE;
        count_nxt      = '0;
      end
    end else if (stg_level_r) begin
      down_nxt = (down_r == '1) ? down_r : down_r + 1'b1;
    end else if (down_r != '0) begin
      // release: sort the press that just ended
      if (down_r > hold_thr_r && kind_r != KIND_TAP) begin
        kind_nxt  = KIND_HOLD;
        count_nxt = count_inc;
      end else if (down_r > tap_thr_r && kind_r != KIND_HOLD) begin
        kind_nxt  = KIND_TAP;
        count_nxt = count_inc;
      end else begin
        finish = 1'b1;
      end
      down_nxt = '0;
      up_nxt   = tick_t'(1);
    end else if (up_r > hold_thr_r) begin
      finish = 1'b1;
    end else begin
      up_nxt = (up_r == '1) ? up_r : up_r + 1'b1;
    end
    // gesture end clears everything; the result uses the pre-clear values
    if (finish) begin
      in_gesture_nxt = 1'b0;
      down_nxt       = '0;
      up_nxt         = '0;
      kind_nxt       = KIND_NONE;
      count_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      in_gesture_r <= 1'b0;
      down_r       <= '0;
      up_r         <= '0;
      kind_r       <= KIND_NONE;
      count_r      <= '0;
    end else if (stg_valid_r && advance) begin
      prev_level_r <= prev_level_nxt;
      in_gesture_r <= in_gesture_nxt;
      down_r       <= down_nxt;
      up_r         <= up_nxt;
      kind_r       <= kind_nxt;
      count_r      <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stg_valid_r && finish;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stg_valid_r && finish) begin
      out_count_r <= count_r;
      out_kind_r  <= kind_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.press_count = out_count_r;
  assign out_ch.press_kind  = out_kind_r;

`include "button_tap_hold_gesture_counter_macros.svh"

  // idle means all gesture counters are clear
  `BTG_ASSERT_NOW(a_idle_clear, !in_gesture_r, down_r == '0 && up_r == '0 && count_r == '0)
  // a counted press always fixes a kind
  `BTG_ASSERT_NOW(a_count_has_kind, in_gesture_r && count_r != '0, kind_r != KIND_NONE)
  // a result with no kind carries no presses
  `BTG_ASSERT_NOW(a_none_zero, out_valid_r && out_kind_r == KIND_NONE, out_count_r == '0)
  // a finishing tick lands in the result register
  `BTG_ASSERT_NEXT(a_finish_shows, stg_valid_r && advance && finish, out_valid_r)
  // the ending tick leaves the block idle
  `BTG_ASSERT_NEXT(a_finish_idle, stg_valid_r && advance && finish, !in_gesture_r)

endmodule

// ===== tb/sv/button_tap_hold_gesture_counter_test.sv =====
`timescale 1ns / 100ps

module button_tap_hold_gesture_counter_test;
  import btg_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT   = 200000;

  // one finished gesture as the block reports it
  typedef struct packed {
    count_t presses;
    kind_t  kind;
  } gesture_t;

  // tracks the gesture state per tick and holds the gestures still to come out
  class gesture_scoreboard;
    tick_t       tap_limit;
    tick_t       hold_limit;
    logic        last_level;
    logic        active;
    tick_t       held;
    tick_t       released;
    kind_t       kind;
    count_t      presses;
    gesture_t    pending_gestures[$];
    int unsigned errors;
    int unsigned ticks_taken;
    int unsigned gestures_predicted;
    int unsigned gestures_checked;

    function new();
      tap_limit          = TAP_THRESHOLD_RST;
      hold_limit         = HOLD_THRESHOLD_RST;
      last_level         = 1'b0;
      active             = 1'b0;
      held               = '0;
      released           = '0;
      kind               = KIND_NONE;
      presses            = '0;
      errors             = 0;
      ticks_taken        = 0;
      gestures_predicted = 0;
      gestures_checked   = 0;
    endfunction

    function void set_threshold(cfg_idx_t idx, tick_t value);
      if (idx == REG_TAP_THRESHOLD) begin
        tap_limit = value;
      end else if (idx == REG_HOLD_THRESHOLD) begin
        hold_limit = value;
      end
    endfunction

    function void count_press(kind_t k);
      kind = k;
      if (presses != '1) presses++;
    endfunction

    // note an accepted tick and queue the gesture it finishes, if any
    function void take_tick(logic level);
      logic     ends;
      gesture_t done;
      ends = 1'b0;
      ticks_taken++;
      if (!active) begin
        if (level && !last_level) begin
          active   = 1'b1;
          held     = tick_t'(1);
          released = '0;
          kind     = KIND_NONE;
          presses  = '0;
        end
      end else if (level) begin
        if (held != '1) held++;
      end else if (held != '0) begin
        // release ends a press: sort it or end the gesture
        if (held > hold_limit && kind != KIND_TAP) begin
          count_press(KIND_HOLD);
        end else if (held > tap_limit && kind != KIND_HOLD) begin
          count_press(KIND_TAP);
        end else begin
          ends = 1'b1;
        end
        held     = '0;
        released = tick_t'(1);
      end else if (released > hold_limit) begin
        ends = 1'b1;
      end else if (released != '1) begin
        released++;
      end
      if (ends) begin
        done.presses = presses;
        done.kind    = kind;
        pending_gestures.push_back(done);
        gestures_predicted++;
        active   = 1'b0;
        held     = '0;
        released = '0;
        kind     = KIND_NONE;
        presses  = '0;
      end
      last_level = level;
    endfunction

    // compare one result beat with the oldest gesture waiting
    function void check_gesture(count_t got_presses, kind_t got_kind);
      gesture_t want;
      gestures_checked++;
      if (pending_gestures.size() == 0) begin
        $display("%0t: unexpected result beat, press_count %0d press_kind %0d",
                 $time, got_presses, got_kind);
        errors++;
      end else begin
        want = pending_gestures.pop_front();
        if (got_presses !== want.presses) begin
          $display("%0t: press_count expected %0d actual %0d",
                   $time, want.presses, got_presses);
          errors++;
        end
        if (got_kind !== want.kind) begin
          $display("%0t: press_kind expected %0d actual %0d",
                   $time, want.kind, got_kind);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  btg_in_if  in_ch();
  btg_out_if out_ch();
  btg_cfg_if cfg_ch();

  gesture_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned take_idle_pct;
  int unsigned cfg_writes;

  button_tap_hold_gesture_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: check each accepted beat, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_gesture(out_ch.press_count, out_ch.press_kind);
    end
    out_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
  end

  // one tick beat, with random gaps before it
  task automatic send_tick(input logic level);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pressed <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_tick(level);
  endtask

  task automatic send_run(input logic level, input int unsigned n);
    repeat (n) send_tick(level);
  endtask

  // stop ticks, let every gesture come out, then let the pipeline empty
  task automatic settle_block();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (sb.pending_gestures.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input cfg_idx_t idx, input tick_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_threshold(idx, value);
    cfg_writes++;
  endtask

  // press length around the current thresholds, capped to keep gestures short
  function automatic int unsigned pick_press_length(int unsigned tl, int unsigned hl);
    int unsigned top;
    top = (hl > tl) ? hl : tl + 1;
    case ($urandom_range(0, 3))
      0:       return (tl == 0) ? 1 : $urandom_range(1, tl);
      1:       return $urandom_range(tl + 1, top);
      2:       return $urandom_range(hl + 1, hl + 3);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // a run of presses with gaps, mostly well formed, ending in silence
  task automatic send_random_gesture();
    int unsigned tl;
    int unsigned hl;
    int unsigned presses;
    tl = (sb.tap_limit > 20) ? 20 : sb.tap_limit;
    hl = (sb.hold_limit > 20) ? 20 : sb.hold_limit;
    presses = $urandom_range(1, 5);
    // occasional noise ahead of the gesture
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
    end
    for (int unsigned i = 0; i < presses; i++) begin
      send_run(1'b1, pick_press_length(tl, hl));
      if (i + 1 < presses) begin
        if ($urandom_range(0, 9) == 0) begin
          send_run(1'b0, $urandom_range(1, hl + 3));
        end else begin
          send_run(1'b0, $urandom_range(1, hl + 1));
        end
      end
    end
    send_run(1'b0, hl + 2);
  endtask

  // random thresholds in chunks of gestures until both goals are met
  task automatic run_random_phase(input int unsigned tick_goal,
                                  input int unsigned gesture_goal);
    int unsigned ticks_start;
    int unsigned gestures_start;
    ticks_start    = sb.ticks_taken;
    gestures_start = sb.gestures_predicted;
    while (sb.ticks_taken - ticks_start < tick_goal ||
           sb.gestures_predicted - gestures_start < gesture_goal) begin
      settle_block();
      if ($urandom_range(0, 5) == 0) begin
        write_threshold(REG_TAP_THRESHOLD, 16'hFFFF);
      end else begin
        write_threshold(REG_TAP_THRESHOLD, tick_t'($urandom_range(0, 12)));
      end
      write_threshold(REG_HOLD_THRESHOLD, tick_t'($urandom_range(0, 12)));
      repeat ($urandom_range(2, 4)) send_random_gesture();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.pressed <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_TAP_THRESHOLD;
    cfg_ch.data   <= '0;
    cfg_writes    = 0;
    send_idle_pct = 33;
    take_idle_pct = 66;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: a tap then a short press
    send_run(1'b1, 81);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    settle_block();

    // directed gestures with tight thresholds
    write_threshold(REG_TAP_THRESHOLD, 1);
    write_threshold(REG_HOLD_THRESHOLD, 3);
    // short first press ends with nothing counted
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    // tap, then a long press still counts as tap, then release timeout
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 5);
    send_run(1'b0, 5);
    // hold, then a short press ends the gesture
    send_run(1'b1, 4);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);

    run_random_phase(80, 5);

    settle_block();
    send_idle_pct = 66;
    take_idle_pct = 33;
    run_random_phase(80, 5);

    // no idling: press count saturation with thresholds at the extremes
    settle_block();
    send_idle_pct = 0;
    take_idle_pct = 0;
    write_threshold(REG_TAP_THRESHOLD, 16'h0000);
    write_threshold(REG_HOLD_THRESHOLD, 16'hFFFF);
    send_run(1'b1, 30);
    send_run(1'b0, 30);
    repeat (259) begin
      send_run(1'b1, 1);
      send_run(1'b0, 1);
    end
    // raise the tap threshold mid gesture so a short press can end it
    settle_block();
    write_threshold(REG_TAP_THRESHOLD, 5);
    send_run(1'b1, 1);
    send_run(1'b0, 1);

    run_random_phase(80, 5);

    settle_block();
    if (sb.pending_gestures.size() != 0) begin
      $display("%0t: %0d gestures never came out", $time, sb.pending_gestures.size());
      sb.errors++;
    end
    $display("run: %0d ticks, %0d gestures checked, %0d threshold writes",
             sb.ticks_taken, sb.gestures_checked, cfg_writes);
    $display("idle mixes on both sides, reset thresholds, extremes and count saturation");
    if (sb.errors == 0) begin
      $display("button_tap_hold_gesture_counter_test passed");
    end else begin
      $display("button_tap_hold_gesture_counter_test failed");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #2000000;
    $display("button_tap_hold_gesture_counter_test failed");
    $finish;
  end

endmodule
